// ===== hdl/hsfc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsfc_pkg: shared definitions for the half/single float converter
// Opcodes, field widths, format constants and the two conversion functions.
// ----------------------------------------------------------------------------
package hsfc_pkg;

    localparam int OPERAND_W = 32;
    localparam int RESULT_W  = 32;
    localparam int HALF_W    = 16;
    localparam int HALF_FW   = 10;

    localparam logic OP_DECODE = 1'b0;
    localparam logic OP_ENCODE = 1'b1;

    localparam logic [15:0] HALF_QNAN      = 16'h7E00;
    localparam logic [15:0] HALF_INF       = 16'h7C00;
    localparam logic [7:0]  EXP_REBIAS     = 8'd112;
    localparam logic [7:0]  SINGLE_EXP_MAX = 8'hFF;
    // Narrowing exponent thresholds on the raw binary32 exponent
    localparam logic [7:0]  ENC_OVF_EXP    = 8'd143;  // half exponent >= 31
    localparam logic [7:0]  ENC_TINY_EXP   = 8'd102;  // below half subnormal range
    localparam logic [7:0]  ENC_SUB_SHIFT  = 8'd126;  // 14 - (re - 112)

    typedef logic [RESULT_W-1:0] word_t;

    // Shift count that brings the leading one of a half subnormal fraction
    // up to the hidden bit position.
    function automatic logic [3:0] half_lzc(input logic [HALF_FW-1:0] f);
        logic [3:0] lz;
        lz = 4'd0;
        for (int i = 0; i < HALF_FW; i++) begin
            if (f[i]) begin
                lz = 4'(HALF_FW - i);
            end
        end
        return lz;
    endfunction

    function automatic word_t widen_half(input logic [HALF_W-1:0] h);
        logic                sgn;
        logic [4:0]          e;
        logic [HALF_FW-1:0]  f;
        logic [3:0]          lz;
        logic [HALF_FW-1:0]  fs;
        logic [7:0]          es;
        word_t               res;
        sgn = h[15];
        e   = h[14:10];
        f   = h[HALF_FW-1:0];
        lz  = half_lzc(f);
        // truncation to the fraction width drops the hidden bit
        fs  = HALF_FW'({6'd0, f} << lz);
        es  = 8'(8'd113 - {4'd0, lz});
        if (e == 5'd0 && f == '0) begin
            res = {sgn, 31'd0};
        end else if (e == 5'd0) begin
            res = {sgn, es, fs, 13'd0};
        end else if (e == 5'd31) begin
            res = {sgn, SINGLE_EXP_MAX, f, 13'd0};
        end else begin
            res = {sgn, 8'({3'd0, e} + EXP_REBIAS), f, 13'd0};
        end
        return res;
    endfunction

    function automatic logic [HALF_W-1:0] narrow_single(input word_t b);
        logic        sgn;
        logic [7:0]  re;
        logic [22:0] m;
        logic [23:0] mh;
        logic [4:0]  sh;
        logic [24:0] rnd;
        logic [24:0] shr;
        logic [24:0] sum_sub;
        logic [10:0] rs;
        logic [23:0] sum_nrm;
        logic [10:0] rm;
        logic [4:0]  eh;
        logic [14:0] mag;
        logic [15:0] sgn_w;
        logic [15:0] res;
        sgn     = b[31];
        re      = b[30:23];
        m       = b[22:0];
        mh      = {1'b1, m};
        sgn_w   = {sgn, 15'd0};
        // subnormal result: variable right shift with round to nearest even
        sh      = 5'(ENC_SUB_SHIFT - re);
        rnd     = (25'd1 << (sh - 5'd1)) - 25'd1;
        shr     = {1'b0, mh} >> sh;
        sum_sub = {1'b0, mh} + rnd + {24'd0, shr[0]};
        rs      = 11'(sum_sub >> sh);
        // normal result: rounding carry may spill into the exponent
        sum_nrm = {1'b0, m} + 24'h000FFF + {23'd0, m[13]};
        rm      = 11'(sum_nrm >> 13);
        eh      = 5'(re - EXP_REBIAS);
        mag     = {eh, 10'd0} + {4'd0, rm};
        if (re == SINGLE_EXP_MAX) begin
            res = sgn_w | ((m == '0) ? HALF_INF : HALF_QNAN);
        end else if (re >= ENC_OVF_EXP) begin
            res = sgn_w | HALF_INF;
        end else if (re < ENC_TINY_EXP) begin
            res = sgn_w;
        end else if (re <= EXP_REBIAS) begin
            res = sgn_w | {5'd0, rs};
        end else begin
            res = sgn_w | {1'b0, mag};
        end
        return res;
    endfunction

endpackage

// ===== hdl/half_single_float_converter.sv =====
`timescale 1ns / 1ps
// An accepted item is held in the input register, then in the result
// register. Throughput: one item per cycle; both registers advance
// together whenever the result register is empty or being drained.
// Reset: synchronous active-low aresetn clears both valid flags; no item is
// held after reset.
// ----------------------------------------------------------------------------
// half_single_float_converter, built from two registers
// Converts binary16 to binary32 (decode) or binary32 to binary16 with
// round-to-nearest-even (encode), one item per cycle unless m_ready stalls.
// ----------------------------------------------------------------------------
module half_single_float_converter (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_op,
    input  logic [hsfc_pkg::OPERAND_W-1:0] s_operand,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [hsfc_pkg::RESULT_W-1:0]  m_result
);
    import hsfc_pkg::*;

    logic                 s1_valid_reg;
    logic                 s1_op_reg;
    logic [OPERAND_W-1:0] s1_operand_reg;
    logic                 m_valid_reg;
    word_t                m_result_reg;

    logic  out_free;
    logic  s1_free;
    word_t conv_next;

    assign out_free = !m_valid_reg || m_ready;
    assign s1_free  = !s1_valid_reg || out_free;
    assign s_ready  = s1_free;

    always_comb begin
        if (s1_op_reg == OP_ENCODE) begin
            conv_next = {16'd0, narrow_single(s1_operand_reg)};
        end else begin
            conv_next = widen_half(s1_operand_reg[HALF_W-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s1_free) begin
                s1_valid_reg <= s_valid;
            end
            if (out_free) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    // payload registers: load on advance, hold otherwise
    always_ff @(posedge aclk) begin
        if (s1_free && s_valid) begin
            s1_op_reg      <= s_op;
            s1_operand_reg <= s_operand;
        end
        if (out_free && s1_valid_reg) begin
            m_result_reg <= conv_next;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid_reg && !s1_valid_reg)
        else $error("pipeline not empty after reset");

    a_stage_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && out_free |=> m_valid_reg)
        else $error("input stage item lost on advance");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && m_valid_reg && !m_ready |=>
            s1_valid_reg && $stable(s1_operand_reg) && $stable(s1_op_reg))
        else $error("input stage changed while stalled");

endmodule
